[src/gap_buffer_line_editor_unit_macros.svh]
// ----------------------------------------------------------------------------
// gap buffer line editor assertion macros
// shared assertion wrappers for the editor block
// ----------------------------------------------------------------------------
`ifndef GAP_BUFFER_LINE_EDITOR_UNIT_MACROS_SVH
`define GAP_BUFFER_LINE_EDITOR_UNIT_MACROS_SVH

// checked only while out of reset
`define GBE_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define GBE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/gbe_pkg.sv]
// ----------------------------------------------------------------------------
// gbe_pkg
// command and status codes, controller states and defaults of the editor
// ----------------------------------------------------------------------------
package gbe_pkg;

    localparam int STORE_DEPTH_DEFAULT = 4096;

    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_LEFT   = 3'd1;
    localparam logic [2:0] CMD_RIGHT  = 3'd2;
    localparam logic [2:0] CMD_BACK   = 3'd3;
    localparam logic [2:0] CMD_READ   = 3'd4;

    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_EDGE  = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [1:0] STAT_RANGE = 2'd3;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

[src/gap_buffer_line_editor_unit.sv]
// ----------------------------------------------------------------------------
// gap_buffer_line_editor_unit
// line edit buffer with a cursor, held as a gap buffer in one byte memory
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries command, char_in and position:
// insert, cursor left, cursor right, backspace or read at a text position.
// Output channel (out_valid/out_ready) returns exactly one result item per
// command: char_out, cursor_pos, text_length and status.
// Each command passes through the idle state, where the accept cycle issues
// the single read of the one-port text memory, and then the execute state,
// which does the write-back and updates the counts. The one memory port is
// why: a cursor move reads one entry and writes another. The result is
// registered in the output register when the execute state completes; a new
// command is not accepted until the execute state is left.
// A new item may be accepted while the previous result still waits in the
// output register; if the receiver stalls, the second item is held in its
// execute cycle (no memory write, no count change) until the output
// register frees up, and input ready stays low meanwhile.
// Reset clears the cursor and length counts; memory contents stay as they
// are and never-written entries are never read. No clearing pass is needed.
// ----------------------------------------------------------------------------
`include "gap_buffer_line_editor_unit_macros.svh"

module gap_buffer_line_editor_unit #(
    parameter int STORE_DEPTH = gbe_pkg::STORE_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  command,
    input  logic [7:0]  char_in,
    input  logic [11:0] position,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  char_out,
    output logic [12:0] cursor_pos,
    output logic [12:0] text_length,
    output logic [1:0]  status
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int PW = (CW > 12) ? CW : 12;
    localparam int XW = (CW > 13) ? CW : 13;
    localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);

    logic [7:0] mem [STORE_DEPTH];

    gbe_pkg::state_t state_reg, state_next;

    logic [CW-1:0] left_reg, left_next;
    logic [CW-1:0] right_reg, right_next;
    logic [2:0]    cmd_reg;
    logic [7:0]    char_reg;
    logic [11:0]   pos_reg;
    logic [7:0]    rd_data_reg;

    logic          out_valid_reg, out_valid_next;
    logic [7:0]    char_out_reg, char_out_next;
    logic [12:0]   cursor_reg, cursor_next;
    logic [12:0]   length_reg, length_next;
    logic [1:0]    status_reg, status_next;

    logic          accept;
    logic          out_free;
    logic          exec_fire;
    logic          mem_re;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;

    logic [CW-1:0] top_base;
    logic [CW-1:0] len_now;
    logic [PW-1:0] left_pw;
    logic [PW-1:0] top_pw;
    logic [PW-1:0] in_pos_pw;
    logic [PW-1:0] reg_pos_pw;
    logic [PW-1:0] len_pw;
    logic [PW-1:0] top_idx;
    logic [CW-1:0] left_dec;
    logic [CW-1:0] top_dec;
    logic [XW-1:0] left_x;
    logic [XW-1:0] len_x;

    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign exec_fire = (state_reg == gbe_pkg::ST_EXEC) && out_free;

    // shared count arithmetic
    assign top_base   = DEPTH_C - right_reg;
    assign top_dec    = top_base - CW'(1);
    assign left_dec   = left_reg - CW'(1);
    assign len_now    = left_reg + right_reg;
    assign left_pw    = PW'(left_reg);
    assign top_pw     = PW'(top_base);
    assign in_pos_pw  = PW'(position);
    assign reg_pos_pw = PW'(pos_reg);
    assign len_pw     = PW'(len_now);
    assign top_idx    = top_pw + (in_pos_pw - left_pw);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gbe_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = gbe_pkg::ST_EXEC;
                end
            end
            gbe_pkg::ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = gbe_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gbe_pkg::ST_IDLE;
            end
        endcase
    end

    // controller outputs
    always_comb
    begin
        in_ready = 1'b0;
        unique case (state_reg)
            gbe_pkg::ST_IDLE: in_ready = 1'b1;
            gbe_pkg::ST_EXEC: in_ready = 1'b0;
            default:          in_ready = 1'b0;
        endcase
    end

    // read side, issued in the accept cycle
    always_comb
    begin
        rd_addr = '0;
        mem_re  = 1'b0;
        case (command)
            gbe_pkg::CMD_LEFT:
            begin
                rd_addr = left_dec[AW-1:0];
                mem_re  = accept && (left_reg != '0);
            end
            gbe_pkg::CMD_RIGHT:
            begin
                rd_addr = top_base[AW-1:0];
                mem_re  = accept && (right_reg != '0);
            end
            gbe_pkg::CMD_READ:
            begin
                if (in_pos_pw < left_pw)
                begin
                    rd_addr = in_pos_pw[AW-1:0];
                end
                else
                begin
                    rd_addr = top_idx[AW-1:0];
                end
                mem_re = accept && (in_pos_pw < len_pw);
            end
            default:
            begin
                rd_addr = '0;
                mem_re  = 1'b0;
            end
        endcase
    end

    // execute cycle: write-back, count update and result
    always_comb
    begin
        wr_addr       = left_reg[AW-1:0];
        wr_data       = char_reg;
        mem_we        = 1'b0;
        left_next     = left_reg;
        right_next    = right_reg;
        char_out_next = 8'd0;
        status_next   = gbe_pkg::STAT_DONE;
        case (cmd_reg)
            gbe_pkg::CMD_INSERT:
            begin
                if (len_now == DEPTH_C)
                begin
                    status_next = gbe_pkg::STAT_FULL;
                end
                else
                begin
                    mem_we    = exec_fire;
                    left_next = left_reg + CW'(1);
                end
            end
            gbe_pkg::CMD_LEFT:
            begin
                if (left_reg == '0)
                begin
                    status_next = gbe_pkg::STAT_EDGE;
                end
                else
                begin
                    wr_addr    = top_dec[AW-1:0];
                    wr_data    = rd_data_reg;
                    mem_we     = exec_fire;
                    left_next  = left_dec;
                    right_next = right_reg + CW'(1);
                end
            end
            gbe_pkg::CMD_RIGHT:
            begin
                if (right_reg == '0)
                begin
                    status_next = gbe_pkg::STAT_EDGE;
                end
                else
                begin
                    wr_data    = rd_data_reg;
                    mem_we     = exec_fire;
                    left_next  = left_reg + CW'(1);
                    right_next = right_reg - CW'(1);
                end
            end
            gbe_pkg::CMD_BACK:
            begin
                if (left_reg == '0)
                begin
                    status_next = gbe_pkg::STAT_EDGE;
                end
                else
                begin
                    left_next = left_dec;
                end
            end
            gbe_pkg::CMD_READ:
            begin
                if (reg_pos_pw >= len_pw)
                begin
                    status_next = gbe_pkg::STAT_RANGE;
                end
                else
                begin
                    char_out_next = rd_data_reg;
                end
            end
            default:
            begin
                status_next = gbe_pkg::STAT_DONE;
            end
        endcase
    end

    assign left_x      = XW'(left_next);
    assign len_x       = XW'(left_next + right_next);
    assign cursor_next = left_x[12:0];
    assign length_next = len_x[12:0];

    assign mem_addr = (state_reg == gbe_pkg::ST_IDLE) ? rd_addr : wr_addr;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (exec_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // text memory, one port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= wr_data;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gbe_pkg::ST_IDLE;
            left_reg      <= '0;
            right_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (exec_fire)
            begin
                left_reg  <= left_next;
                right_reg <= right_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= command;
            char_reg <= char_in;
            pos_reg  <= position;
        end
        if (exec_fire)
        begin
            char_out_reg <= char_out_next;
            cursor_reg   <= cursor_next;
            length_reg   <= length_next;
            status_reg   <= status_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign char_out    = char_out_reg;
    assign cursor_pos  = cursor_reg;
    assign text_length = length_reg;
    assign status      = status_reg;

    `GBE_ASSERT_ALWAYS(a_len_bound, (len_now <= DEPTH_C), "text length exceeds store depth")
    `GBE_ASSERT_RST(a_accept_exec, (accept |=> state_reg == gbe_pkg::ST_EXEC), "accepted item did not execute")
    `GBE_ASSERT_RST(a_port_conflict, (!(mem_we && mem_re)), "read and write on the single memory port")
    `GBE_ASSERT_RST(a_stall_hold, (state_reg == gbe_pkg::ST_EXEC && !out_free |=> $stable(left_reg) && $stable(right_reg)), "counts moved while result stalled")

endmodule

[test/tb_gap_buffer_line_editor_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gap_buffer_line_editor_unit
// self-checking bench for the gap buffer line editor
// ----------------------------------------------------------------------------
// A short command script covers the empty-buffer edges, spare command codes,
// out-of-range reads and moves across the cursor. Random edit streams follow
// under several idle and stall mixes. One run holds the output off long
// enough to back the input up. Each result is compared with a fixed script
// value or with a behavioral editor model kept in step with the accepted commands.
// ----------------------------------------------------------------------------
module tb_gap_buffer_line_editor_unit;

    localparam int TEXT_DEPTH = gbe_pkg::STORE_DEPTH_DEFAULT;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 150;
    localparam int SETTLE_CYCLES = 8;

    localparam logic [2:0] CMD_SPARE_LO  = 3'd5;
    localparam logic [2:0] CMD_SPARE_MID = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI  = 3'd7;

    typedef struct packed {
        logic [7:0]  ch;
        logic [12:0] cursor;
        logic [12:0] length;
        logic [1:0]  stat;
    } edit_result_t;

    typedef struct packed {
        logic [2:0]   cmd;
        logic [7:0]   ch;
        logic [11:0]  pos;
        logic         fixed;
        edit_result_t want;
    } script_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  command;
    logic [7:0]  char_in;
    logic [11:0] position;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  char_out;
    logic [12:0] cursor_pos;
    logic [12:0] text_length;
    logic [1:0]  status;

    logic         want_fixed;
    edit_result_t fixed_result;
    logic         hold_active = 1'b0;
    event         hold_go;

    int unsigned  in_idle_pct = 0;
    int unsigned  out_stall_pct = 0;
    int unsigned  cycle_count = 0;
    int unsigned  mismatch_count = 0;

    logic [7:0]   text_mem [TEXT_DEPTH];
    int unsigned  left_len = 0;
    int unsigned  right_len = 0;

    edit_result_t pending_results [$];
    script_row_t  script_rows [$];

    gap_buffer_line_editor_unit #(
        .STORE_DEPTH(TEXT_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .command(command),
        .char_in(char_in),
        .position(position),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .char_out(char_out),
        .cursor_pos(cursor_pos),
        .text_length(text_length),
        .status(status)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic edit_result_t predict_edit(input logic [2:0] cmd,
                                                  input logic [7:0] ch,
                                                  input logic [11:0] pos);
        edit_result_t r;
        int unsigned  used;
        r = '0;
        used = left_len + right_len;
        case (cmd)
            gbe_pkg::CMD_INSERT:
                if (used >= TEXT_DEPTH)
                    r.stat = gbe_pkg::STAT_FULL;
                else
                begin
                    text_mem[left_len] = ch;
                    left_len++;
                end
            gbe_pkg::CMD_LEFT:
                if (left_len == 0)
                    r.stat = gbe_pkg::STAT_EDGE;
                else
                begin
                    text_mem[TEXT_DEPTH - right_len - 1] = text_mem[left_len - 1];
                    left_len--;
                    right_len++;
                end
            gbe_pkg::CMD_RIGHT:
                if (right_len == 0)
                    r.stat = gbe_pkg::STAT_EDGE;
                else
                begin
                    text_mem[left_len] = text_mem[TEXT_DEPTH - right_len];
                    left_len++;
                    right_len--;
                end
            gbe_pkg::CMD_BACK:
                if (left_len == 0)
                    r.stat = gbe_pkg::STAT_EDGE;
                else
                    left_len--;
            gbe_pkg::CMD_READ:
                if (pos >= used)
                    r.stat = gbe_pkg::STAT_RANGE;
                else if (pos < left_len)
                    r.ch = text_mem[pos];
                else
                    r.ch = text_mem[TEXT_DEPTH - right_len + (pos - left_len)];
            default:
                ;
        endcase
        r.cursor = 13'(left_len);
        r.length = 13'(left_len + right_len);
        return r;
    endfunction

    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch on %s at cycle %0d: got %0d, expected %0d",
                 field, cycle_count, got, want);
        mismatch_count++;
    endtask

    // results are popped before the new command is predicted
    always @(posedge clk)
    begin : result_check
        edit_result_t want;
        edit_result_t next;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("result with nothing pending", 1, 0);
                else
                begin
                    want = pending_results.pop_front();
                    if (char_out !== want.ch)
                        report_mismatch("char_out", char_out, want.ch);
                    if (cursor_pos !== want.cursor)
                        report_mismatch("cursor_pos", cursor_pos, want.cursor);
                    if (text_length !== want.length)
                        report_mismatch("text_length", text_length, want.length);
                    if (status !== want.stat)
                        report_mismatch("status", status, want.stat);
                end
            end
            if (in_valid && in_ready)
            begin
                next = predict_edit(command, char_in, position);
                pending_results.push_back(want_fixed ? fixed_result : next);
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_active)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
    end

    initial
    begin
        forever
        begin
            @(hold_go);
            @(posedge clk);
            hold_active <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_active <= 1'b0;
        end
    end

    task automatic send_item(input logic [2:0] cmd, input logic [7:0] ch,
                             input logic [11:0] pos, input logic fixed,
                             input edit_result_t want);
        if ($urandom_range(0, 99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < in_idle_pct)
                @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        char_in      <= ch;
        position     <= pos;
        want_fixed   <= fixed;
        fixed_result <= want;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic send_random_edit();
        logic [2:0]  cmd;
        logic [7:0]  ch;
        logic [11:0] pos;
        int unsigned pick;
        int unsigned used;
        pick = $urandom_range(0, 99);
        used = left_len + right_len;
        ch = 8'($urandom_range(0, 255));
        pos = 12'($urandom_range(0, 4095));
        if (pick < 30)
            cmd = gbe_pkg::CMD_INSERT;
        else if (pick < 45)
            cmd = gbe_pkg::CMD_LEFT;
        else if (pick < 60)
            cmd = gbe_pkg::CMD_RIGHT;
        else if (pick < 70)
            cmd = gbe_pkg::CMD_BACK;
        else if (pick < 95)
        begin
            cmd = gbe_pkg::CMD_READ;
            if (used != 0 && pick < 90)
                pos = 12'($urandom_range(0, used - 1));
        end
        else
            cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        send_item(cmd, ch, pos, 1'b0, '0);
    endtask

    task automatic finish_phase();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_random(input int count, input int unsigned idle,
                              input int unsigned stall);
        in_idle_pct = idle;
        out_stall_pct = stall;
        repeat (count) send_random_edit();
        finish_phase();
    endtask

    task automatic add_row(input logic fixed, input logic [2:0] cmd,
                           input logic [7:0] ch, input logic [11:0] pos,
                           input logic [7:0] rd, input logic [12:0] cur,
                           input logic [12:0] len, input logic [1:0] stat);
        script_row_t row;
        row.cmd = cmd;
        row.ch = ch;
        row.pos = pos;
        row.fixed = fixed;
        row.want = '{ch: rd, cursor: cur, length: len, stat: stat};
        script_rows.push_back(row);
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        command      <= gbe_pkg::CMD_INSERT;
        char_in      <= 8'h00;
        position     <= 12'h000;
        want_fixed   <= 1'b0;
        fixed_result <= '0;

        // empty buffer edges and spare codes
        add_row(1, gbe_pkg::CMD_LEFT,   8'h00, 12'h000, 8'h00, 0, 0, gbe_pkg::STAT_EDGE);
        add_row(1, gbe_pkg::CMD_RIGHT,  8'hFF, 12'hFFF, 8'h00, 0, 0, gbe_pkg::STAT_EDGE);
        add_row(1, gbe_pkg::CMD_BACK,   8'h00, 12'h000, 8'h00, 0, 0, gbe_pkg::STAT_EDGE);
        add_row(1, gbe_pkg::CMD_READ,   8'h00, 12'h000, 8'h00, 0, 0, gbe_pkg::STAT_RANGE);
        add_row(1, gbe_pkg::CMD_READ,   8'hFF, 12'hFFF, 8'h00, 0, 0, gbe_pkg::STAT_RANGE);
        add_row(1, CMD_SPARE_LO,        8'hFF, 12'hFFF, 8'h00, 0, 0, gbe_pkg::STAT_DONE);
        add_row(1, CMD_SPARE_HI,        8'h00, 12'h000, 8'h00, 0, 0, gbe_pkg::STAT_DONE);
        // short text, moves across the cursor
        add_row(1, gbe_pkg::CMD_INSERT, 8'h00, 12'hFFF, 8'h00, 1, 1, gbe_pkg::STAT_DONE);
        add_row(1, gbe_pkg::CMD_INSERT, 8'hFF, 12'h000, 8'h00, 2, 2, gbe_pkg::STAT_DONE);
        add_row(1, gbe_pkg::CMD_READ,   8'hFF, 12'h000, 8'h00, 2, 2, gbe_pkg::STAT_DONE);
        add_row(1, gbe_pkg::CMD_READ,   8'h00, 12'h001, 8'hFF, 2, 2, gbe_pkg::STAT_DONE);
        add_row(1, gbe_pkg::CMD_READ,   8'h00, 12'h002, 8'h00, 2, 2, gbe_pkg::STAT_RANGE);
        add_row(1, gbe_pkg::CMD_LEFT,   8'h00, 12'h000, 8'h00, 1, 2, gbe_pkg::STAT_DONE);
        add_row(0, gbe_pkg::CMD_READ,   8'h00, 12'h001, 8'h00, 0, 0, gbe_pkg::STAT_DONE);
        add_row(1, gbe_pkg::CMD_INSERT, 8'hA5, 12'h000, 8'h00, 2, 3, gbe_pkg::STAT_DONE);
        add_row(1, gbe_pkg::CMD_RIGHT,  8'h00, 12'h000, 8'h00, 3, 3, gbe_pkg::STAT_DONE);
        add_row(1, gbe_pkg::CMD_RIGHT,  8'h00, 12'h000, 8'h00, 3, 3, gbe_pkg::STAT_EDGE);
        add_row(1, gbe_pkg::CMD_BACK,   8'h00, 12'h000, 8'h00, 2, 2, gbe_pkg::STAT_DONE);
        add_row(0, gbe_pkg::CMD_READ,   8'h00, 12'h001, 8'h00, 0, 0, gbe_pkg::STAT_DONE);
        add_row(1, CMD_SPARE_MID,       8'h5A, 12'h555, 8'h00, 2, 2, gbe_pkg::STAT_DONE);
        add_row(1, gbe_pkg::CMD_READ,   8'h00, 12'h800, 8'h00, 2, 2, gbe_pkg::STAT_RANGE);
        add_row(1, gbe_pkg::CMD_LEFT,   8'h00, 12'h000, 8'h00, 1, 2, gbe_pkg::STAT_DONE);
        add_row(1, gbe_pkg::CMD_LEFT,   8'h00, 12'h000, 8'h00, 0, 2, gbe_pkg::STAT_DONE);
        add_row(1, gbe_pkg::CMD_LEFT,   8'h00, 12'h000, 8'h00, 0, 2, gbe_pkg::STAT_EDGE);
        add_row(0, gbe_pkg::CMD_READ,   8'h00, 12'h000, 8'h00, 0, 0, gbe_pkg::STAT_DONE);
        add_row(1, gbe_pkg::CMD_BACK,   8'h00, 12'h000, 8'h00, 0, 2, gbe_pkg::STAT_EDGE);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script_rows[i])
            send_item(script_rows[i].cmd, script_rows[i].ch, script_rows[i].pos,
                      script_rows[i].fixed, script_rows[i].want);
        finish_phase();

        run_random(320, 0, 0);
        run_random(320, 72, 0);
        run_random(320, 0, 72);
        run_random(320, 6, 6);

        // output held off while commands keep coming
        in_idle_pct = 0;
        out_stall_pct = 0;
        -> hold_go;
        repeat (40) send_random_edit();
        finish_phase();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("results still pending", pending_results.size(), 0);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/gbe_pkg.sv
src/gap_buffer_line_editor_unit.sv
test/tb_gap_buffer_line_editor_unit.sv
